// ===== src/cppr_pkg.sv =====
// Shared constants and types for the closest prime pair block.
// Used by cppr_store, cppr_sieve, cppr_scan and closest_prime_pair_in_range_core.
// No dependencies.
package cppr_pkg;

  // Bitmap covers 0 .. SIEVE_SIZE-1
  localparam int SIEVE_SIZE = 65536;
  localparam int ADDR_W     = $clog2(SIEVE_SIZE);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int DATA_W     = 16;
  // Wide enough for a clamped bound and for a raw 16-bit input compare
  localparam int WIDE_W     = (CNT_W > DATA_W + 1) ? CNT_W : DATA_W + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SIEVE_SIZE - 1);

  // Access request to the bitmap memory
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_bit;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // One query result
  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] first_prime;
    logic [DATA_W-1:0] second_prime;
  } result_t;

endpackage

// ===== src/cppr_store.sv =====
// Primality bitmap memory: one write port, one read port, registered read data.
// Selects the sieve builder's requests until the sieve is done, then the scanner's.
// Depends on cppr_pkg.
module cppr_store (
  input  logic                clk,
  input  logic                sieve_done,
  input  cppr_pkg::mem_req_t  sieve_req,
  input  cppr_pkg::mem_req_t  scan_req,
  output logic                rd_bit
);

  logic               mem [cppr_pkg::SIEVE_SIZE];
  cppr_pkg::mem_req_t req;

  // Hand the port to the scanner once the bitmap is complete
  assign req = sieve_done ? scan_req : sieve_req;

  // Write, and read through a register
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_bit;
    end
    rd_bit <= mem[req.rd_addr];
  end

endmodule

// ===== src/cppr_sieve.sv =====
// Sieve builder: fills the bitmap with the odd-number pattern, then clears
// multiples of each odd prime from its square upward. Depends on cppr_pkg.
module cppr_sieve (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_bit,
  output cppr_pkg::mem_req_t req,
  output logic               done
);

  localparam int AW = cppr_pkg::ADDR_W;
  localparam int CW = cppr_pkg::CNT_W;
  localparam int SW = 2 * cppr_pkg::ADDR_W;
  localparam logic [SW-1:0] SQ_LIMIT = SW'(cppr_pkg::SIEVE_SIZE);
  localparam logic [CW-1:0] SIZE_CNT = CW'(cppr_pkg::SIEVE_SIZE);

  typedef enum logic [2:0] {FILL, TEST, CHECK, MARK, DONE} state_t;

  state_t          state;
  logic [AW-1:0]   fill_addr;
  logic [AW-1:0]   cand;
  logic [CW-1:0]   mult;
  logic [CW-1:0]   mult_next;
  logic [SW-1:0]   cand_sq;
  logic            fill_bit;

  assign cand_sq   = {{AW{1'b0}}, cand} * {{AW{1'b0}}, cand};
  assign mult_next = mult + {1'b0, cand};

  // Initial pattern: 2 and every odd number from 3 are candidates
  assign fill_bit = (fill_addr == AW'(2)) || (fill_addr[0] && (fill_addr != AW'(1)));

  // Memory requests
  always_comb begin
    req.wr_en   = (state == FILL) || (state == MARK);
    req.wr_addr = (state == FILL) ? fill_addr : mult[AW-1:0];
    req.wr_bit  = (state == FILL) ? fill_bit : 1'b0;
    req.rd_addr = cand;
  end

  assign done = (state == DONE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FILL;
      fill_addr <= '0;
      cand      <= AW'(3);
    end else begin
      case (state)
        FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == cppr_pkg::LAST_ADDR) begin
            state <= TEST;
          end
        end
        // Read the candidate bit while its square is in range
        TEST: begin
          if (cand_sq < SQ_LIMIT) begin
            state <= CHECK;
          end else begin
            state <= DONE;
          end
        end
        CHECK: begin
          if (rd_bit) begin
            mult  <= CW'(cand_sq);
            state <= MARK;
          end else begin
            cand  <= cand + AW'(2);
            state <= TEST;
          end
        end
        // Clear one multiple per cycle
        MARK: begin
          mult <= mult_next;
          if (mult_next >= SIZE_CNT) begin
            cand  <= cand + AW'(2);
            state <= TEST;
          end
        end
        DONE: begin
          state <= DONE;
        end
        default: begin
          state <= FILL;
        end
      endcase
    end
  end

endmodule

// ===== src/cppr_scan.sv =====
// Query scanner: reads one bitmap entry per cycle over the clamped range and
// tracks the adjacent prime pair with the smallest gap. Depends on cppr_pkg.
module cppr_scan (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sieve_done,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [cppr_pkg::DATA_W-1:0] range_low,
  input  logic [cppr_pkg::DATA_W-1:0] range_high,
  output cppr_pkg::mem_req_t       req,
  input  logic                     rd_bit,
  output logic                     res_valid,
  output cppr_pkg::result_t        res,
  input  logic                     res_ready
);

  localparam int AW = cppr_pkg::ADDR_W;
  localparam int WW = cppr_pkg::WIDE_W;
  localparam int DW = cppr_pkg::DATA_W;
  localparam logic [WW-1:0] LAST_W = WW'(cppr_pkg::SIEVE_SIZE - 1);

  typedef enum logic [1:0] {IDLE, RUN, DRAIN, FINISH} state_t;

  state_t        state;
  logic [WW-1:0] lo_w;
  logic [WW-1:0] hi_w;
  logic [WW-1:0] hi_c;
  logic [WW-1:0] cursor;
  logic [WW-1:0] last_idx;
  logic          pend;
  logic [WW-1:0] pend_idx;
  logic          have_prev;
  logic          have_pair;
  logic [WW-1:0] prev;
  logic [WW-1:0] best_gap;
  logic [WW-1:0] pair_lo;
  logic [WW-1:0] pair_hi;
  logic [WW-1:0] gap;
  logic          take;

  // Clamp the upper bound to the bitmap
  assign lo_w = WW'(range_low);
  assign hi_w = WW'(range_high);
  assign hi_c = (hi_w > LAST_W) ? LAST_W : hi_w;

  // Pair update on a prime returned from memory
  assign gap  = pend_idx - prev;
  assign take = pend && rd_bit && have_prev && (!have_pair || (gap < best_gap));

  assign in_ready  = sieve_done && (state == IDLE);
  assign res_valid = (state == FINISH);

  always_comb begin
    res.found        = have_pair;
    res.first_prime  = have_pair ? DW'(pair_lo) : '0;
    res.second_prime = have_pair ? DW'(pair_hi) : '0;
  end

  // Read-only access
  always_comb begin
    req.wr_en   = 1'b0;
    req.wr_addr = '0;
    req.wr_bit  = 1'b0;
    req.rd_addr = cursor[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      pend      <= 1'b0;
      have_prev <= 1'b0;
      have_pair <= 1'b0;
    end else begin
      pend <= (state == RUN);
      // Evaluate the entry read in the previous cycle
      if (pend && rd_bit) begin
        prev      <= pend_idx;
        have_prev <= 1'b1;
        if (take) begin
          best_gap  <= gap;
          pair_lo   <= prev;
          pair_hi   <= pend_idx;
          have_pair <= 1'b1;
        end
      end
      case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            have_prev <= 1'b0;
            have_pair <= 1'b0;
            cursor    <= lo_w;
            last_idx  <= hi_c;
            state     <= (lo_w > hi_c) ? FINISH : RUN;
          end
        end
        // Issue one read per cycle up to the last index
        RUN: begin
          pend_idx <= cursor;
          cursor   <= cursor + WW'(1);
          if (cursor == last_idx) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= FINISH;
        end
        // Hold the result until the output stage takes it
        FINISH: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/closest_prime_pair_in_range_core.sv =====
// Top level of the closest prime pair block: bitmap memory, sieve builder,
// query scanner and output register. Depends on cppr_pkg, cppr_store,
// cppr_sieve and cppr_scan.
//
// Usage:
//   Input words on s_* carry a closed range [range_low, range_high]; each
//   accepted word yields exactly one result word on m_*: found on m_tuser,
//   and the closest adjacent prime pair (earliest on a tie) on m_tdata, both
//   zero when the range holds fewer than two primes or low exceeds high.
//   After rst the block builds the bitmap: it fills every entry, then tests
//   each odd candidate up to the square root and clears the multiples of
//   each prime among them. s_tready stays low until this finishes.
//   A query scans (min(range_high, SIEVE_SIZE-1) - range_low + 1) entries;
//   an empty range goes straight to the result without a scan. The single
//   read port of the bitmap, one entry per cycle, sets the scan time. One
//   query is in work at a time.
//   The result sits in an output register; while m_tready is low the scanner
//   may finish the next query and holds it until the register frees up.
module closest_prime_pair_in_range_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // range_low [15:0], range_high [31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // first_prime [15:0], second_prime [31:16]
  output logic        m_tuser    // found [0]
);

  localparam int DW = cppr_pkg::DATA_W;

  cppr_pkg::mem_req_t sieve_req;
  cppr_pkg::mem_req_t scan_req;
  cppr_pkg::result_t  res;
  cppr_pkg::result_t  out_res;
  logic               sieve_done;
  logic               rd_bit;
  logic               res_valid;
  logic               res_ready;

  cppr_store u_store (
    .clk        (clk),
    .sieve_done (sieve_done),
    .sieve_req  (sieve_req),
    .scan_req   (scan_req),
    .rd_bit     (rd_bit)
  );

  cppr_sieve u_sieve (
    .clk    (clk),
    .rst    (rst),
    .rd_bit (rd_bit),
    .req    (sieve_req),
    .done   (sieve_done)
  );

  cppr_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .sieve_done (sieve_done),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .range_low  (s_tdata[DW-1:0]),
    .range_high (s_tdata[2*DW-1:DW]),
    .req        (scan_req),
    .rd_bit     (rd_bit),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
        out_res  <= res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {out_res.second_prime, out_res.first_prime};
  assign m_tuser = out_res.found;

endmodule

// ===== bench/tb_closest_prime_pair_in_range_core.sv =====
// Self-checking bench for closest_prime_pair_in_range_core: range queries in,
// closest adjacent prime pairs out, predicted against a local sieve table.
// Depends on cppr_pkg and the closest_prime_pair_in_range_core RTL.
`timescale 1ns / 1ps

module tb_closest_prime_pair_in_range_core;

  typedef struct {
    logic [15:0] lo;
    logic [15:0] hi;
    int          gap;    // idle cycles before the word is offered
    bit          drain;  // hold the word until every result is back
  } range_query_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  bit                prime_tbl [cppr_pkg::SIEVE_SIZE];
  range_query_t      range_q [$];
  cppr_pkg::result_t pair_q [$];
  range_query_t      cur_query;
  cppr_pkg::result_t cur_pair;
  cppr_pkg::result_t exp_pair;
  bit                word_up;
  int                gap_left;
  int                stall_left;
  int                query_total;
  int                sent_count;
  int                got_count;
  int                fail_count;
  int                pair_count;
  int                none_count;
  int                widest_scan;
  longint            scan_budget;
  longint            cycle_count;
  longint            cycle_limit;

  closest_prime_pair_in_range_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sieve of Eratosthenes over the whole bitmap
  function automatic void build_prime_table();
    int i;
    int j;
    for (i = 0; i < cppr_pkg::SIEVE_SIZE; i++) begin
      prime_tbl[i] = (i == 2) || ((i >= 3) && (i % 2 == 1));
    end
    for (i = 3; i * i < cppr_pkg::SIEVE_SIZE; i += 2) begin
      if (prime_tbl[i]) begin
        for (j = i * i; j < cppr_pkg::SIEVE_SIZE; j += i) prime_tbl[j] = 1'b0;
      end
    end
  endfunction

  // Walk the primes of [lo, hi] and keep the first pair with the smallest gap
  function automatic cppr_pkg::result_t closest_pair(logic [15:0] lo, logic [15:0] hi);
    cppr_pkg::result_t r;
    int                p;
    int                top;
    int                prev;
    int                best_gap;
    bit                have_prev;
    r         = '0;
    prev      = 0;
    best_gap  = 0;
    have_prev = 1'b0;
    top = (int'(hi) > cppr_pkg::SIEVE_SIZE - 1) ? cppr_pkg::SIEVE_SIZE - 1 : int'(hi);
    for (p = int'(lo); p <= top; p++) begin
      if (prime_tbl[p]) begin
        if (have_prev && (!r.found || (p - prev) < best_gap)) begin
          best_gap       = p - prev;
          r.found        = 1'b1;
          r.first_prime  = 16'(prev);
          r.second_prime = 16'(p);
        end
        prev      = p;
        have_prev = 1'b1;
      end
    end
    return r;
  endfunction

  // Queue one query and add its worst-case scan time to the cycle budget
  task automatic add_query(int lo, int hi, int gap, bit drain);
    range_query_t q;
    int           span;
    q.lo    = 16'(lo);
    q.hi    = 16'(hi);
    q.gap   = gap;
    q.drain = drain;
    range_q = {range_q, q};
    span = (hi >= lo) ? hi - lo + 1 : 0;
    if (span > widest_scan) widest_scan = span;
    scan_budget += span + 10 + 34;
    query_total++;
  endtask

  // Present queued words, holding each until it is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      word_up  = 1'b0;
      gap_left = -1;
    end else begin
      if (s_tvalid && s_tready) begin
        pair_q = {pair_q, cur_pair};
        sent_count++;
        word_up = 1'b0;
      end
      if (!word_up && range_q.size() > 0) begin
        if (gap_left < 0) gap_left = range_q[0].gap;
        if (range_q[0].drain && pair_q.size() != 0) begin
          // hold off until the block has drained
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          cur_query = range_q.pop_front();
          cur_pair  = closest_pair(cur_query.lo, cur_query.hi);
          word_up   = 1'b1;
          gap_left  = -1;
          s_tdata  <= {cur_query.hi, cur_query.lo};
        end
      end
      s_tvalid <= word_up;
    end
  end

  // Take result words with random back-pressure and compare them
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pair_q.size() == 0) begin
          $error("unexpected result: found %0b first %0d second %0d",
                 m_tuser, m_tdata[15:0], m_tdata[31:16]);
          fail_count++;
        end else begin
          exp_pair = pair_q.pop_front();
          if (m_tuser !== exp_pair.found) begin
            $error("found: expected %0b, got %0b", exp_pair.found, m_tuser);
            fail_count++;
          end
          if (m_tdata[15:0] !== exp_pair.first_prime) begin
            $error("first_prime: expected %0d, got %0d",
                   exp_pair.first_prime, m_tdata[15:0]);
            fail_count++;
          end
          if (m_tdata[31:16] !== exp_pair.second_prime) begin
            $error("second_prime: expected %0d, got %0d",
                   exp_pair.second_prime, m_tdata[31:16]);
            fail_count++;
          end
          if (exp_pair.found) pair_count++;
          else none_count++;
        end
        got_count++;
        // every third window of results runs with no stall at all
        if (((got_count / 12) % 3) == 2) stall_left = 0;
        else stall_left = $urandom_range(0, 16);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
  end

  // Watchdog
  initial begin
    #1;
    wait (cycle_limit != 0 && cycle_count >= cycle_limit);
    $display("closest_prime_pair_in_range_core regression: fail");
    $finish;
  end

  initial begin
    int i;
    int kind;
    int lo;
    int hi;
    int large_left;
    build_prime_table();

    // Directed: full scan offered while the sieve is still running
    add_query(0, 65535, 0, 1'b0);
    add_query(2, 3, $urandom_range(0, 16), 1'b0);
    add_query(2, 2, $urandom_range(0, 16), 1'b0);
    add_query(0, 1, 0, 1'b0);
    add_query(1, 1, $urandom_range(0, 16), 1'b0);
    add_query(0, 0, 0, 1'b0);
    add_query(100, 50, $urandom_range(0, 16), 1'b1);
    add_query(65535, 0, 0, 1'b0);
    add_query(65535, 65535, $urandom_range(0, 16), 1'b0);
    add_query(65521, 65521, 0, 1'b0);
    add_query(65500, 65535, $urandom_range(0, 16), 1'b0);
    // tie between equal gaps: earliest pair must win
    add_query(3, 13, 0, 1'b0);
    add_query(24, 28, $urandom_range(0, 16), 1'b0);
    add_query(23, 29, 0, 1'b0);
    add_query(7, 11, $urandom_range(0, 16), 1'b0);
    add_query(89, 97, 0, 1'b0);
    add_query(113, 127, $urandom_range(0, 16), 1'b0);
    // wide prime gap
    add_query(31397, 31469, 0, 1'b0);
    add_query(16'hAAAA, 16'hAAFF, $urandom_range(0, 16), 1'b0);
    add_query(16'h5555, 16'h55AA, 0, 1'b0);
    add_query(32000, 65535, $urandom_range(0, 16), 1'b0);

    // Random: mostly short windows anywhere, a few wide scans
    large_left = 3;
    for (i = 0; i < 80; i++) begin
      kind = $urandom_range(0, 19);
      lo   = $urandom_range(0, 65535);
      hi   = lo + $urandom_range(0, 300);
      if (kind == 13 || kind == 14) begin
        hi = (lo > 0) ? lo - $urandom_range(1, lo) : 0;
        if (lo == 0) lo = $urandom_range(1, 65535);
      end else if (kind == 15) begin
        lo = $urandom_range(0, 4);
        hi = $urandom_range(0, 60);
      end else if (kind == 16) begin
        lo = $urandom_range(65300, 65535);
        hi = $urandom_range(lo, 65535);
      end else if (kind == 17) begin
        lo = $urandom_range(0, 2000);
        hi = lo + $urandom_range(0, 50);
      end else if (kind == 18) begin
        hi = lo + $urandom_range(0, 3000);
      end else if (kind == 19 && large_left > 0) begin
        hi = lo + $urandom_range(0, 20000);
        large_left--;
      end
      if (hi > 65535) hi = 65535;
      add_query(lo, hi, (((i / 10) % 4) == 3) ? 0 : $urandom_range(0, 16),
                $urandom_range(0, 24) == 0);
    end

    // sieve build plus every scan, gap and stall, taken four times over
    cycle_limit = 4 * (200000 + scan_budget);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (sent_count != query_total) @(posedge clk);
    while (pair_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d range queries checked: %0d with a closest pair, %0d without",
             got_count, pair_count, none_count);
    $display("widest scan %0d entries, finished after %0d cycles",
             widest_scan, cycle_count);
    if (fail_count == 0) begin
      $display("closest_prime_pair_in_range_core regression: pass");
    end else begin
      $display("closest_prime_pair_in_range_core regression: fail");
    end
    $finish;
  end

endmodule
